@@ rtl/core/otp_pkg.sv @@
// ----------------------------------------------------------------------------
// One-shot timer pool package
// Shared sizes, request codes and status codes of the timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package otp_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int DELAY_W   = 32;
	localparam int ID_W      = 8;
	localparam int CNT_W     = 7;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_COUNTING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ERROR    = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/one_shot_timer_pool_top.sv @@
// ----------------------------------------------------------------------------
// One-shot timer pool
// A pool of one-shot countdown timers served by a slot-serial sequencer.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------
//   in       | input     | in_valid / in_stall | func, delay_ticks, timer_id
//   out      | output    | out_valid/out_stall | result_id, status, expired_now,
//            |           |                     | pending_count
//
// Each request is taken at the accept edge, walked slot by slot through the shared
// slot update unit, and then loaded into the result register.
// Reset frees all slots; remaining counts are not cleared and are written by add.
// in_stall is high from the accept until the result is loaded; the result
// register holds while out_stall is high, and the block waits to load a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_pool_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [otp_pkg::FUNC_W-1:0]         func,
	input  wire logic [otp_pkg::DELAY_W-1:0]        delay_ticks,
	input  wire logic [otp_pkg::ID_W-1:0]           timer_id,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [otp_pkg::ID_W-1:0]                result_id,
	output logic [otp_pkg::STATUS_W-1:0]            status,
	output logic [otp_pkg::CNT_W-1:0]               expired_now,
	output logic [otp_pkg::CNT_W-1:0]               pending_count
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [otp_pkg::SLOT_W-1:0] LAST_SLOT =
		otp_pkg::SLOT_W'(otp_pkg::NUM_SLOTS - 1);

	logic [1:0]                       state_q;
	logic [otp_pkg::SLOT_W-1:0]       idx_q;

	logic [otp_pkg::NUM_SLOTS-1:0]    busy_q;
	logic [otp_pkg::NUM_SLOTS-1:0]    exp_q;
	logic [otp_pkg::DELAY_W-1:0]      rem_q [otp_pkg::NUM_SLOTS];

	logic [otp_pkg::FUNC_W-1:0]       func_q;
	logic [otp_pkg::DELAY_W-1:0]      delay_q;
	logic [otp_pkg::ID_W-1:0]         id_q;

	// Accumulated result of the request being walked.
	logic                             found_q;
	logic [otp_pkg::ID_W-1:0]         rid_q;
	logic [otp_pkg::STATUS_W-1:0]     stat_q;
	logic [otp_pkg::CNT_W-1:0]        exp_cnt_q;
	logic [otp_pkg::CNT_W-1:0]        pend_cnt_q;

	logic                             out_valid_q;
	logic [otp_pkg::ID_W-1:0]         out_rid_q;
	logic [otp_pkg::STATUS_W-1:0]     out_stat_q;
	logic [otp_pkg::CNT_W-1:0]        out_exp_q;
	logic [otp_pkg::CNT_W-1:0]        out_pend_q;

	// Shared slot update unit.
	logic                             cur_busy;
	logic                             cur_exp;
	logic [otp_pkg::DELAY_W-1:0]      cur_rem;
	logic [otp_pkg::ID_W-1:0]         cur_id;
	logic                             id_hit;
	logic                             new_busy;
	logic                             new_exp;
	logic [otp_pkg::DELAY_W-1:0]      new_rem;
	logic                             rem_wr;
	logic                             new_found;
	logic [otp_pkg::ID_W-1:0]         new_rid;
	logic [otp_pkg::STATUS_W-1:0]     new_stat;
	logic                             exp_inc;

	logic in_acc;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign cur_busy = busy_q[idx_q];
	assign cur_exp  = exp_q[idx_q];
	assign cur_rem  = rem_q[idx_q];
	assign cur_id   = {{(otp_pkg::ID_W-otp_pkg::SLOT_W){1'b0}}, idx_q} + 1'b1;
	assign id_hit   = (cur_id == id_q);

	always_comb begin
		new_busy  = cur_busy;
		new_exp   = cur_exp;
		new_rem   = cur_rem - 1'b1;
		rem_wr    = 1'b0;
		new_found = found_q;
		new_rid   = rid_q;
		new_stat  = stat_q;
		exp_inc   = 1'b0;
		case (func_q)
			otp_pkg::FUNC_TICK: begin
				if (cur_busy && !cur_exp) begin
					if (cur_rem == '0) begin
						new_exp = 1'b1;
						exp_inc = 1'b1;
					end else begin
						rem_wr = 1'b1;
					end
				end
			end
			otp_pkg::FUNC_ADD: begin
				// The first free slot in the walk is the lowest-numbered one.
				if (!cur_busy && !found_q) begin
					new_busy  = 1'b1;
					new_exp   = 1'b0;
					new_rem   = delay_q;
					rem_wr    = 1'b1;
					new_found = 1'b1;
					new_rid   = cur_id;
					new_stat  = otp_pkg::STATUS_DONE;
				end
			end
			otp_pkg::FUNC_CANCEL: begin
				if (id_hit && cur_busy) begin
					new_busy = 1'b0;
					new_exp  = 1'b0;
					new_stat = otp_pkg::STATUS_DONE;
				end
			end
			otp_pkg::FUNC_QUERY: begin
				if (id_hit && cur_busy) begin
					if (cur_exp) begin
						new_busy = 1'b0;
						new_exp  = 1'b0;
						new_stat = otp_pkg::STATUS_TIMEOUT;
					end else begin
						new_stat = otp_pkg::STATUS_COUNTING;
					end
				end
			end
			default: begin
				new_stat = otp_pkg::STATUS_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			busy_q      <= '0;
			exp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FLUSH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SWEEP;
						idx_q   <= '0;
					end
				end
				ST_SWEEP: begin
					busy_q[idx_q] <= new_busy;
					exp_q[idx_q]  <= new_exp;
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, walk accumulators, slot counts and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q     <= func;
			delay_q    <= delay_ticks;
			id_q       <= timer_id;
			found_q    <= 1'b0;
			rid_q      <= '0;
			exp_cnt_q  <= '0;
			pend_cnt_q <= '0;
			// A tick always succeeds; every other request fails unless a slot serves it.
			stat_q     <= (func == otp_pkg::FUNC_TICK) ? otp_pkg::STATUS_DONE
				: otp_pkg::STATUS_ERROR;
		end
		if (state_q == ST_SWEEP) begin
			if (rem_wr) begin
				rem_q[idx_q] <= new_rem;
			end
			found_q    <= new_found;
			rid_q      <= new_rid;
			stat_q     <= new_stat;
			exp_cnt_q  <= exp_cnt_q + {{(otp_pkg::CNT_W-1){1'b0}}, exp_inc};
			pend_cnt_q <= pend_cnt_q + {{(otp_pkg::CNT_W-1){1'b0}}, (new_busy && !new_exp)};
		end
		if (state_q == ST_FLUSH && out_free) begin
			out_rid_q  <= rid_q;
			out_stat_q <= stat_q;
			out_exp_q  <= exp_cnt_q;
			out_pend_q <= pend_cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_id     = out_rid_q;
	assign status        = out_stat_q;
	assign expired_now   = out_exp_q;
	assign pending_count = out_pend_q;

endmodule

`default_nettype wire
